>>> hw/rtl/blfmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blfmc_pkg: shared types and constants of the line-follow balance controller
// Line geometry, configuration register map, register reset values, result
// beat layout and the steering divide helper.
// ----------------------------------------------------------------------------
package blfmc_pkg;

    // Line sensor geometry
    localparam int LINE_WIDTH = 128;
    localparam int IDX_W      = $clog2(LINE_WIDTH);
    localparam int HALF_W     = LINE_WIDTH / 2;

    // Fixed field widths
    localparam int CENTER_W = 7;
    localparam int STEER_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Divide by ten through a reciprocal: exact for operands below 2^16
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DARK_THRESHOLD = 3'd0,
        REG_SPEED_SETPOINT = 3'd1,
        REG_TILT_GAIN      = 3'd2,
        REG_RATE_GAIN      = 3'd3,
        REG_TRAVEL_GAIN    = 3'd4,
        REG_SPEED_GAIN     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic        [7:0]  dark_threshold;
        logic signed [15:0] speed_setpoint;
        logic        [7:0]  tilt_gain;
        logic        [7:0]  rate_gain;
        logic        [7:0]  travel_gain;
        logic        [7:0]  speed_gain;
    } cfg_t;

    localparam logic [7:0]         RST_DARK_THRESHOLD = 8'd100;
    localparam logic signed [15:0] RST_SPEED_SETPOINT = 16'sd77;
    localparam logic [7:0]         RST_TILT_GAIN      = 8'd10;
    localparam logic [7:0]         RST_RATE_GAIN      = 8'd10;
    localparam logic [7:0]         RST_TRAVEL_GAIN    = 8'd20;
    localparam logic [7:0]         RST_SPEED_GAIN     = 8'd10;

    // One control tick handed from the line tracker to the drive pipeline
    typedef struct packed {
        logic signed [15:0] gyro_rate;
        logic signed [15:0] wheel_speed;
        logic [IDX_W-1:0]   center;
    } tick_t;

    typedef struct packed {
        logic signed [15:0]        left_motor;
        logic signed [15:0]        right_motor;
        logic signed [STEER_W-1:0] steer;
        logic [CENTER_W-1:0]       line_center;
        logic signed [15:0]        tilt_drive;
    } result_t;

    // (center - LINE_WIDTH/2) / 10, truncated toward zero
    function automatic logic signed [STEER_W-1:0] steer_of(input logic [IDX_W-1:0] center);
        logic signed [IDX_W:0]  diff;
        logic [IDX_W-1:0]       mag;
        logic [IDX_W+15:0]      prod;
        logic [IDX_W-1:0]       quo;
        diff = $signed({1'b0, center}) - $signed((IDX_W+1)'(HALF_W));
        mag  = diff[IDX_W] ? IDX_W'(-diff) : diff[IDX_W-1:0];
        prod = (IDX_W+16)'(mag) * (IDX_W+16)'(DIV10_MUL);
        quo  = IDX_W'(prod >> DIV10_SHIFT);
        return diff[IDX_W] ? $signed(STEER_W'(-quo)) : $signed(STEER_W'(quo));
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/balance_line_follow_motor_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// balance_line_follow_motor_control: line-follow balance motor controller
// Tracks the dark line edges over one sensor line and, on its last pixel,
// runs one balance tick that yields both motor commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one line sensor pixel per beat in index order, with tlast on
//   the final pixel of the line. Gyro rate and wheel speed ride in tdata and
//   are used only on the tlast beat.
//   Output stream: one beat per line, carrying left/right motor commands,
//   steering, line center and tilt drive.
//   Throughput: one input beat per cycle while s_tready is high. The tlast
//   beat's result comes out of the five-stage drive pipeline (integrate, gain
//   multiply, sum, scale/saturate, motor mix).
//   Stall: a result waiting on m_tready holds in the output register while
//   the pipeline keeps filling; s_tready drops only once all five stages hold
//   a result.
//   Configuration: write cfg_data to register cfg_index with cfg_we, only
//   while no line end is in flight. Writes to unknown indexes are dropped.
//   Reset: accumulators cleared, edges at their empty-line values, registers
//   at their defaults, no results pending.
// ----------------------------------------------------------------------------
module balance_line_follow_motor_control
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // slave stream
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    input  wire logic [39:0]                        s_tdata,  // pixel, gyro_rate, wheel_speed
    input  wire logic                               s_tlast,  // last_pixel
    // master stream
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    output      logic [63:0]                        m_tdata,  // left_motor, right_motor,
                                                              // steer, line_center,
                                                              // tilt_drive, zero pad
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [blfmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [blfmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    blfmc_pkg::cfg_t    cfg_reg;
    blfmc_pkg::tick_t   tick;
    blfmc_pkg::result_t result;

    logic                          in_beat;
    logic                          drv_ready;
    logic                          drv_busy;
    logic [blfmc_pkg::IDX_W-1:0]   center;

    // Accept a beat whenever the drive pipeline has room for a line end
    assign s_tready = drv_ready;
    assign in_beat  = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold <= blfmc_pkg::RST_DARK_THRESHOLD;
            cfg_reg.speed_setpoint <= blfmc_pkg::RST_SPEED_SETPOINT;
            cfg_reg.tilt_gain      <= blfmc_pkg::RST_TILT_GAIN;
            cfg_reg.rate_gain      <= blfmc_pkg::RST_RATE_GAIN;
            cfg_reg.travel_gain    <= blfmc_pkg::RST_TRAVEL_GAIN;
            cfg_reg.speed_gain     <= blfmc_pkg::RST_SPEED_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                blfmc_pkg::REG_DARK_THRESHOLD: cfg_reg.dark_threshold <= cfg_data[7:0];
                blfmc_pkg::REG_SPEED_SETPOINT: cfg_reg.speed_setpoint <= $signed(cfg_data);
                blfmc_pkg::REG_TILT_GAIN:      cfg_reg.tilt_gain      <= cfg_data[7:0];
                blfmc_pkg::REG_RATE_GAIN:      cfg_reg.rate_gain      <= cfg_data[7:0];
                blfmc_pkg::REG_TRAVEL_GAIN:    cfg_reg.travel_gain    <= cfg_data[7:0];
                blfmc_pkg::REG_SPEED_GAIN:     cfg_reg.speed_gain     <= cfg_data[7:0];
                default:                       ;
            endcase
        end
    end

    // Edge tracking runs on every accepted pixel; center includes this pixel
    blfmc_edge u_edge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (in_beat),
        .pixel     (s_tdata[7:0]),
        .last      (s_tlast),
        .threshold (cfg_reg.dark_threshold),
        .center    (center)
    );

    assign tick.gyro_rate   = $signed(s_tdata[23:8]);
    assign tick.wheel_speed = $signed(s_tdata[39:24]);
    assign tick.center      = center;

    // Only line ends enter the drive pipeline
    blfmc_drive u_drive
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid && s_tlast),
        .in_ready   (drv_ready),
        .in_tick    (tick),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .busy       (drv_busy)
    );

    assign m_tdata = {5'b0, result.tilt_drive, result.line_center, result.steer,
                      result.right_motor, result.left_motor};

    // A line end that is taken must show up in the pipeline next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> drv_busy)
        else $error("accepted line end did not enter the drive pipeline");

    // An empty pipeline never back-pressures the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !drv_busy |-> s_tready)
        else $error("input stalled with an empty drive pipeline");

    // Nothing is presented when no line end is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> drv_busy)
        else $error("result beat without a line end in flight");

    // Steering stays within the span of half a line divided by ten
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(result.steer) >= -4'sd6 && $signed(result.steer) <= 4'sd6))
        else $error("steering out of range");

endmodule
`default_nettype wire

>>> hw/rtl/blfmc_edge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blfmc_edge: line edge tracker
// Follows the pixel index, keeps the left and right dark edges and gives the
// line center including the pixel on the current beat.
// ----------------------------------------------------------------------------
module blfmc_edge
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        beat,
    input  wire logic [7:0]                  pixel,
    input  wire logic                        last,
    input  wire logic [7:0]                  threshold,
    output      logic [blfmc_pkg::IDX_W-1:0] center
);

    localparam int IW = blfmc_pkg::IDX_W;

    logic [IW-1:0] idx_reg,   idx_next;
    logic [IW-1:0] left_reg,  left_next;
    logic [IW-1:0] right_reg, right_next;
    logic          found_reg, found_next;

    logic          dark;
    logic          hit_left;
    logic          hit_right;
    logic [IW-1:0] left_now;
    logic [IW-1:0] right_now;
    logic [IW:0]   edge_sum;

    always_comb
    begin
        dark      = pixel < threshold;
        hit_left  = dark && (idx_reg >= IW'(1)) && (idx_reg <= IW'(blfmc_pkg::HALF_W));
        hit_right = dark && !found_reg && (idx_reg >= IW'(blfmc_pkg::HALF_W))
                    && (idx_reg <= IW'(blfmc_pkg::LINE_WIDTH - 2));
        left_now  = hit_left  ? idx_reg : left_reg;
        right_now = hit_right ? idx_reg : right_reg;
        edge_sum  = (IW+1)'(left_now) + (IW+1)'(right_now);
        center    = edge_sum[IW:1];
    end

    always_comb
    begin
        idx_next   = idx_reg;
        left_next  = left_reg;
        right_next = right_reg;
        found_next = found_reg;
        if (beat)
        begin
            if (last)
            begin
                // end of line: back to the empty-line state
                idx_next   = '0;
                left_next  = '0;
                right_next = IW'(blfmc_pkg::LINE_WIDTH - 1);
                found_next = 1'b0;
            end
            else
            begin
                left_next  = left_now;
                right_next = right_now;
                found_next = found_reg || hit_right;
                if (idx_reg < IW'(blfmc_pkg::LINE_WIDTH - 1))
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            left_reg  <= '0;
            right_reg <= IW'(blfmc_pkg::LINE_WIDTH - 1);
            found_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            found_reg <= found_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/blfmc_drive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blfmc_drive: balance drive pipeline
// Integrates gyro rate and speed error, weights them by the gains, scales
// and saturates the drive and forms both motor commands over five stages.
// ----------------------------------------------------------------------------
module blfmc_drive
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire blfmc_pkg::cfg_t    cfg,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire blfmc_pkg::tick_t   in_tick,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      blfmc_pkg::result_t out_result,
    output      logic               busy
);

    localparam int IW = blfmc_pkg::IDX_W;
    localparam int SW = blfmc_pkg::STEER_W;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31])
        begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16_34(input logic signed [34:0] v);
        if (v > 35'sd32767)
        begin
            return 16'sh7fff;
        end
        if (v < -35'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] sat16_18(input logic signed [17:0] v);
        if (v > 18'sd32767)
        begin
            return 16'sh7fff;
        end
        if (v < -18'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Stage valids and readiness
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdyo;
    logic fire;

    // Accumulators
    logic signed [31:0] tilt_acc_reg, tilt_acc_next;
    logic signed [31:0] travel_acc_reg, travel_acc_next;
    logic signed [16:0] speed_err;

    // Stage payloads
    logic signed [15:0] gyro1_reg, speed1_reg;
    logic signed [31:0] tilt1_reg, travel1_reg;
    logic [IW-1:0]      center1_reg, center2_reg, center3_reg, center4_reg;
    logic signed [40:0] pt2_reg, pv2_reg;
    logic signed [24:0] pr2_reg, ps2_reg;
    logic signed [SW-1:0] steer2_reg, steer3_reg, steer4_reg;
    logic signed [42:0] sum3_reg;
    logic signed [15:0] drive4_reg;
    blfmc_pkg::result_t res_reg;

    logic signed [42:0] sum3_next;
    logic signed [42:0] rounded;
    logic signed [34:0] quo;
    logic signed [17:0] left_sum, right_sum;

    assign rdyo     = !vo_reg || out_ready;
    assign rdy4     = !v4_reg || rdyo;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign fire     = in_valid && rdy1;

    assign out_valid  = vo_reg;
    assign out_result = res_reg;
    assign busy       = v1_reg || v2_reg || v3_reg || v4_reg || vo_reg;

    always_comb
    begin
        speed_err       = 17'(in_tick.wheel_speed) - 17'(cfg.speed_setpoint);
        tilt_acc_next   = sat32(33'(tilt_acc_reg) + 33'(in_tick.gyro_rate));
        travel_acc_next = sat32(33'(travel_acc_reg) + 33'(speed_err));

        sum3_next = 43'(pt2_reg) + 43'(pr2_reg) - 43'(pv2_reg) - 43'(ps2_reg);

        // divide by 256 truncating toward zero
        rounded = sum3_reg + (sum3_reg[42] ? 43'sd255 : 43'sd0);
        quo     = rounded[42:8];

        left_sum  = 18'(steer4_reg) - 18'(drive4_reg);
        right_sum = -18'(steer4_reg) - 18'(drive4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            vo_reg         <= 1'b0;
            tilt_acc_reg   <= '0;
            travel_acc_reg <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdyo)
            begin
                vo_reg <= v4_reg;
            end
            if (fire)
            begin
                tilt_acc_reg   <= tilt_acc_next;
                travel_acc_reg <= travel_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            gyro1_reg   <= in_tick.gyro_rate;
            speed1_reg  <= in_tick.wheel_speed;
            tilt1_reg   <= tilt_acc_next;
            travel1_reg <= travel_acc_next;
            center1_reg <= in_tick.center;
        end
        if (rdy2 && v1_reg)
        begin
            pt2_reg     <= 41'($signed({1'b0, cfg.tilt_gain})) * 41'(tilt1_reg);
            pr2_reg     <= 25'($signed({1'b0, cfg.rate_gain})) * 25'(gyro1_reg);
            pv2_reg     <= 41'($signed({1'b0, cfg.travel_gain})) * 41'(travel1_reg);
            ps2_reg     <= 25'($signed({1'b0, cfg.speed_gain})) * 25'(speed1_reg);
            center2_reg <= center1_reg;
            steer2_reg  <= blfmc_pkg::steer_of(center1_reg);
        end
        if (rdy3 && v2_reg)
        begin
            sum3_reg    <= sum3_next;
            center3_reg <= center2_reg;
            steer3_reg  <= steer2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            drive4_reg  <= sat16_34(quo);
            center4_reg <= center3_reg;
            steer4_reg  <= steer3_reg;
        end
        if (rdyo && v4_reg)
        begin
            res_reg.left_motor  <= sat16_18(left_sum);
            res_reg.right_motor <= sat16_18(right_sum);
            res_reg.steer       <= steer4_reg;
            res_reg.line_center <= blfmc_pkg::CENTER_W'(center4_reg);
            res_reg.tilt_drive  <= drive4_reg;
        end
    end

endmodule
`default_nettype wire

>>> dv/tb_balance_line_follow_motor_control.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_balance_line_follow_motor_control: self-checking bench for the line-follow
// balance motor controller
// Streams sensor lines into the block with random valid gaps and output
// stalls. A scoreboard tracks the line edges, the tilt and travel integrators
// and the register settings, and checks every motor command field by field.
// ----------------------------------------------------------------------------
module tb_balance_line_follow_motor_control;

    // Register indexes past the map: writes to them must be dropped
    localparam logic [blfmc_pkg::CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [blfmc_pkg::CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;
    localparam longint OUT_MAX = 64'sd32767;
    localparam longint OUT_MIN = -64'sd32768;

    localparam int RANDOM_BEATS  = 1400;
    localparam int RANDOM_LINES  = 16;
    localparam int SETTLE        = 20;      // settle margin once no command is owed
    localparam int QUIET_LIMIT   = 2000;    // cycles with no beat on either side

    typedef enum int {
        PIX_UNIFORM,
        PIX_SPARSE,
        PIX_BAND,
        PIX_CENTER,
        PIX_BRIGHT
    } pix_style_t;

    // ------------------------------------------------------------------------
    // Scoreboard: line edge tracker, integrators and the queue of motor
    // commands still owed by the block
    // ------------------------------------------------------------------------
    class motor_cmd_scoreboard;
        logic [7:0]         dark_thr;
        logic signed [15:0] setpoint;
        logic [7:0]         k_tilt;
        logic [7:0]         k_rate;
        logic [7:0]         k_travel;
        logic [7:0]         k_speed;
        longint             tilt_sum;
        longint             travel_sum;
        int                 px_idx;
        int                 left_edge;
        int                 right_edge;
        bit                 right_found;
        blfmc_pkg::result_t cmd_q[$];
        int                 errors;
        int                 n_beats;
        int                 n_lines;
        int                 n_cmds;

        function new();
            dark_thr   = blfmc_pkg::RST_DARK_THRESHOLD;
            setpoint   = blfmc_pkg::RST_SPEED_SETPOINT;
            k_tilt     = blfmc_pkg::RST_TILT_GAIN;
            k_rate     = blfmc_pkg::RST_RATE_GAIN;
            k_travel   = blfmc_pkg::RST_TRAVEL_GAIN;
            k_speed    = blfmc_pkg::RST_SPEED_GAIN;
            tilt_sum   = 0;
            travel_sum = 0;
            errors     = 0;
            n_beats    = 0;
            n_lines    = 0;
            n_cmds     = 0;
            restart_line();
        endfunction

        function void restart_line();
            px_idx      = 0;
            left_edge   = 0;
            right_edge  = blfmc_pkg::LINE_WIDTH - 1;
            right_found = 1'b0;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function void set_reg(logic [blfmc_pkg::CFG_IDX_W-1:0] idx,
                              logic [blfmc_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                blfmc_pkg::REG_DARK_THRESHOLD: dark_thr = val[7:0];
                blfmc_pkg::REG_SPEED_SETPOINT: setpoint = val;
                blfmc_pkg::REG_TILT_GAIN:      k_tilt   = val[7:0];
                blfmc_pkg::REG_RATE_GAIN:      k_rate   = val[7:0];
                blfmc_pkg::REG_TRAVEL_GAIN:    k_travel = val[7:0];
                blfmc_pkg::REG_SPEED_GAIN:     k_speed  = val[7:0];
                default:                       ;
            endcase
        endfunction

        function int pending();
            return cmd_q.size();
        endfunction

        // Advance the edge tracker by one pixel; on the last pixel run the tick
        function void note_beat(logic [7:0] pix, bit last,
                                logic signed [15:0] gyro, logic signed [15:0] speed);
            bit                 dark;
            longint             sum;
            longint             drive;
            longint             center;
            longint             steer_v;
            blfmc_pkg::result_t cmd;
            dark = (pix < dark_thr);
            n_beats++;
            // pixel zero is never an edge; the centre pixel may set both
            if (dark && px_idx >= 1 && px_idx <= blfmc_pkg::HALF_W)
                left_edge = px_idx;
            if (dark && !right_found && px_idx >= blfmc_pkg::HALF_W
                && px_idx <= blfmc_pkg::LINE_WIDTH - 2)
            begin
                right_edge  = px_idx;
                right_found = 1'b1;
            end
            if (px_idx < blfmc_pkg::LINE_WIDTH - 1)
                px_idx++;
            if (!last)
                return;

            n_lines++;
            tilt_sum   = clamp(tilt_sum + longint'(gyro), ACC_MIN, ACC_MAX);
            travel_sum = clamp(travel_sum + longint'(speed) - longint'(setpoint),
                               ACC_MIN, ACC_MAX);
            sum = longint'(k_tilt) * tilt_sum + longint'(k_rate) * longint'(gyro)
                - longint'(k_travel) * travel_sum - longint'(k_speed) * longint'(speed);
            drive   = clamp(sum / 256, OUT_MIN, OUT_MAX);
            center  = (left_edge + right_edge) / 2;
            steer_v = (center - blfmc_pkg::HALF_W) / 10;

            cmd.left_motor  = 16'(clamp(steer_v - drive, OUT_MIN, OUT_MAX));
            cmd.right_motor = 16'(clamp(-steer_v - drive, OUT_MIN, OUT_MAX));
            cmd.steer       = 4'(steer_v);
            cmd.line_center = 7'(center);
            cmd.tilt_drive  = 16'(drive);
            cmd_q.push_back(cmd);
            restart_line();
        endfunction

        static function int field_bad(string name, longint want, longint got);
            if (want == got)
                return 0;
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        endfunction

        // Compare one output beat with the oldest owed command
        function void check_result(logic [63:0] beat);
            blfmc_pkg::result_t want;
            if (cmd_q.size() == 0)
            begin
                $error("motor command beat %h arrived with none expected", beat);
                errors++;
                return;
            end
            want = cmd_q.pop_front();
            n_cmds++;
            errors += field_bad("left_motor",  want.left_motor,  $signed(beat[15:0]));
            errors += field_bad("right_motor", want.right_motor, $signed(beat[31:16]));
            errors += field_bad("steer",       want.steer,       $signed(beat[35:32]));
            errors += field_bad("line_center", want.line_center, beat[42:36]);
            errors += field_bad("tilt_drive",  want.tilt_drive,  $signed(beat[58:43]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its stimulus signals, all known from time zero
    // ------------------------------------------------------------------------
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [39:0]                      s_tdata   = '0;   // pixel, gyro_rate, wheel_speed
    logic                             s_tlast   = 1'b0; // last_pixel
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [63:0]                      m_tdata;          // left_motor, right_motor, steer,
                                                        // line_center, tilt_drive, pad
    logic                             cfg_we    = 1'b0;
    logic [blfmc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [blfmc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    motor_cmd_scoreboard sb;
    bit                  idle_on    = 1'b1;
    int                  stall_left = 0;

    balance_line_follow_motor_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------

    // Gap length for either side: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Q8.8 value: extremes, small values that keep the drive off its rails,
    // or anything at all
    function automatic logic signed [15:0] pick_q88();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'sh8000;
        if (r < 10)
            return 16'sh7fff;
        if (r < 45)
            return 16'($urandom_range(0, 1023) - 512);
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_u8();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'd0;
        if (r < 30)
            return 8'd255;
        return 8'($urandom);
    endfunction

    // Pixel on the requested side of the current dark threshold
    function automatic logic [7:0] make_pixel(input bit dark);
        int thr;
        thr = sb.dark_thr;
        if (dark && thr > 0)
            return 8'($urandom_range(0, thr - 1));
        return 8'($urandom_range(thr, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one pixel beat and hold it until the block takes it. Keep valid
    // high across back-to-back beats; drop it only for a gap.
    task automatic send_beat(input logic [7:0] pix, input bit last,
                             input logic signed [15:0] gyro,
                             input logic signed [15:0] speed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {speed, gyro, pix};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(pix, last, gyro, speed);
    endtask

    // One sensor line; gyro and speed only matter on the closing beat
    task automatic send_line(input int len, input pix_style_t style);
        int         band_lo;
        int         band_hi;
        bit         dark;
        logic [7:0] pix;
        band_lo = $urandom_range(0, blfmc_pkg::LINE_WIDTH - 1);
        band_hi = band_lo + $urandom_range(0, 20);
        for (int i = 0; i < len; i++)
        begin
            case (style)
                PIX_SPARSE: dark = ($urandom_range(0, 19) == 0);
                PIX_BAND:   dark = (i >= band_lo && i <= band_hi);
                PIX_CENTER: dark = (i == blfmc_pkg::HALF_W);
                default:    dark = 1'b0;
            endcase
            pix = (style == PIX_UNIFORM) ? 8'($urandom) : make_pixel(dark);
            if (i == len - 1)
                send_beat(pix, 1'b1, pick_q88(), pick_q88());
            else
                send_beat(pix, 1'b0, 16'($urandom), 16'($urandom));
        end
    endtask

    // Leave cfg_we high; the caller drops it after its last write
    task automatic write_reg(input logic [blfmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [blfmc_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // Hold until every owed command is back, then let the pipeline settle
    task automatic wait_drained(input int settle);
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // New value for every register; junk in the unused upper byte of the
    // 8-bit ones, and now and then a write to an index past the map
    task automatic shuffle_registers();
        logic [7:0] junk;
        junk = 8'($urandom);
        write_reg(blfmc_pkg::REG_DARK_THRESHOLD, {junk, pick_u8()});
        write_reg(blfmc_pkg::REG_SPEED_SETPOINT, pick_q88());
        write_reg(blfmc_pkg::REG_TILT_GAIN,      {~junk, pick_u8()});
        write_reg(blfmc_pkg::REG_RATE_GAIN,      {junk, pick_u8()});
        write_reg(blfmc_pkg::REG_TRAVEL_GAIN,    {~junk, pick_u8()});
        write_reg(blfmc_pkg::REG_SPEED_GAIN,     {junk, pick_u8()});
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each accepted beat, then pick the next ready level
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (stall_left > 0)
            begin
                m_tready   <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                m_tready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if neither stream moves for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int         n_settings;
        int         beats0;
        int         lines0;
        int         len;
        int         r;
        pix_style_t style;

        sb         = new();
        n_settings = 1;

        // Hold reset, then release it on an edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: lone dark pixel zero with extreme gyro and speed,
        // then short lines closing early with dark pixels near the left end
        send_beat(8'd0, 1'b1, 16'sh7fff, 16'sh8000);
        send_beat(8'd255, 1'b0, 16'($urandom), 16'($urandom));
        send_beat(8'd0, 1'b0, 16'($urandom), 16'($urandom));
        send_beat(8'd99, 1'b1, 16'sh8000, 16'sh7fff);
        send_beat(8'd100, 1'b0, 16'($urandom), 16'($urandom));
        send_beat(8'd1, 1'b1, 16'sh0001, 16'shffff);
        s_tvalid <= 1'b0;
        wait_drained(SETTLE);

        // Setpoint at bottom, all else at top; writes past the map must change nothing
        write_reg(REG_UNUSED_6, 16'hffff);
        write_reg(REG_UNUSED_7, 16'h0000);
        write_reg(blfmc_pkg::REG_DARK_THRESHOLD, 16'hffff);
        write_reg(blfmc_pkg::REG_SPEED_SETPOINT, 16'h8000);
        write_reg(blfmc_pkg::REG_TILT_GAIN,      16'h00ff);
        write_reg(blfmc_pkg::REG_RATE_GAIN,      16'hffff);
        write_reg(blfmc_pkg::REG_TRAVEL_GAIN,    16'h00ff);
        write_reg(blfmc_pkg::REG_SPEED_GAIN,     16'hffff);
        cfg_we <= 1'b0;
        n_settings++;
        send_beat(8'd255, 1'b0, 16'($urandom), 16'($urandom));
        send_beat(8'd254, 1'b0, 16'($urandom), 16'($urandom));
        send_beat(8'd255, 1'b0, 16'($urandom), 16'($urandom));
        send_beat(8'd0, 1'b1, 16'sh7fff, 16'sh7fff);
        send_beat(8'd255, 1'b1, 16'sh8000, 16'sh8000);
        s_tvalid <= 1'b0;
        wait_drained(SETTLE);

        // Setpoint at top, all else at bottom: nothing is dark and the drive is zero
        write_reg(blfmc_pkg::REG_DARK_THRESHOLD, 16'hff00);
        write_reg(blfmc_pkg::REG_SPEED_SETPOINT, 16'h7fff);
        write_reg(blfmc_pkg::REG_TILT_GAIN,      16'hff00);
        write_reg(blfmc_pkg::REG_RATE_GAIN,      16'h0000);
        write_reg(blfmc_pkg::REG_TRAVEL_GAIN,    16'hff00);
        write_reg(blfmc_pkg::REG_SPEED_GAIN,     16'h0000);
        cfg_we <= 1'b0;
        n_settings++;
        send_beat(8'd0, 1'b0, 16'($urandom), 16'($urandom));
        send_beat(8'd0, 1'b0, 16'($urandom), 16'($urandom));
        send_beat(8'd255, 1'b1, 16'sh7fff, 16'sh8000);
        s_tvalid <= 1'b0;
        wait_drained(SETTLE);

        // Random phases: new settings, then a batch of lines of every shape.
        // Some lines are complete; short and overlong ones test early close
        // and index saturation.
        beats0 = sb.n_beats;
        lines0 = sb.n_lines;
        while ((sb.n_beats - beats0) < RANDOM_BEATS || (sb.n_lines - lines0) < RANDOM_LINES)
        begin
            shuffle_registers();
            n_settings++;
            idle_on = ($urandom_range(0, 4) != 0);
            repeat ($urandom_range(3, 10))
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    len = blfmc_pkg::LINE_WIDTH;
                else if (r < 70)
                    len = $urandom_range(1, 40);
                else if (r < 85)
                    len = $urandom_range(41, blfmc_pkg::LINE_WIDTH - 1);
                else
                    len = $urandom_range(blfmc_pkg::LINE_WIDTH + 1, 200);
                style = pix_style_t'($urandom_range(0, 4));
                send_line(len, style);
                // now and then hold the sender until the block has caught up
                if ($urandom_range(0, 9) == 0)
                begin
                    s_tvalid <= 1'b0;
                    wait_drained(0);
                end
            end
            s_tvalid <= 1'b0;
            wait_drained(SETTLE);
        end

        $display("Checked %0d motor commands from %0d pixel beats over %0d register settings,",
                 sb.n_cmds, sb.n_beats, n_settings);
        $display("with short, full and overlong lines and the drive pushed onto both rails.");
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/blfmc_pkg.sv
hw/rtl/blfmc_edge.sv
hw/rtl/blfmc_drive.sv
hw/rtl/balance_line_follow_motor_control.sv
dv/tb_balance_line_follow_motor_control.sv
